/* src/ffla_pkg.sv */
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared widths, codes and result type of the free-list record allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffla_pkg;

  localparam int unsigned REC_W           = 9;
  localparam int unsigned ACT_W           = 2;
  localparam int unsigned STAT_W          = 2;
  localparam int unsigned NUM_RECORDS_DEF = 256;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [REC_W-1:0] granted_record;
    logic             busy_res;
    status_t          status;
  } ffla_result_t;

endpackage

`default_nettype wire

/* src/ffla_if.sv */
// ----------------------------------------------------------------------------
// ffla_if
// Valid/ready channels for requests and results of the record allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffla_in_if;
  logic                        valid;
  logic                        ready;
  logic [ffla_pkg::ACT_W-1:0]  action;
  logic [ffla_pkg::REC_W-1:0]  record_number;

  modport source (output valid, action, record_number, input ready);
  modport sink   (input valid, action, record_number, output ready);
endinterface

interface ffla_out_if;
  logic                        valid;
  logic                        ready;
  logic [ffla_pkg::REC_W-1:0]  granted_record;
  logic                        busy_res;
  logic [ffla_pkg::STAT_W-1:0] status;

  modport source (output valid, granted_record, busy_res, status, input ready);
  modport sink   (input valid, granted_record, busy_res, status, output ready);
endinterface

`default_nettype wire

/* src/ffla_next_mem.sv */
// ----------------------------------------------------------------------------
// ffla_next_mem
// Next-pointer memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffla_next_mem #(
  parameter int unsigned DEPTH = ffla_pkg::NUM_RECORDS_DEF + 1,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ADDR_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ADDR_W-1:0] wr_data
);

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/ffla_engine.sv */
// ----------------------------------------------------------------------------
// ffla_engine
// Head/tail registers, clearing pass and read-modify-write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ffla_engine #(
  parameter int unsigned NUM_RECORDS = ffla_pkg::NUM_RECORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ffla_pkg::ACT_W-1:0] in_action,
  input  logic [ffla_pkg::REC_W-1:0] in_record_number,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ffla_pkg::ffla_result_t     res
);

  import ffla_pkg::*;

  localparam int unsigned PTR_W = $clog2(NUM_RECORDS + 1);
  localparam int unsigned CMP_W = (PTR_W > REC_W) ? PTR_W : REC_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(NUM_RECORDS);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC} state_t;

  state_t           state_r;
  logic [PTR_W-1:0] clr_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [ACT_W-1:0] act_r;
  logic [PTR_W-1:0] n_r;
  logic             range_ok_r;

  logic [CMP_W-1:0] n_ext;
  logic             n_ok;
  logic [PTR_W-1:0] n_in;
  logic             accept;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] mem_q;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] wr_data;
  logic             is_busy;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign n_ext    = CMP_W'(in_record_number);
  assign n_ok     = (n_ext != '0) && (n_ext <= CMP_W'(NUM_RECORDS));
  assign n_in     = n_ok ? PTR_W'(n_ext) : '0;

  // Allocate reads the head entry; free and query read their own entry.
  assign rd_en   = accept;
  assign rd_addr = (in_action == ACT_ALLOC) ? head_r : n_in;

  ffla_next_mem #(
    .DEPTH (NUM_RECORDS + 1)
  ) u_next_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // A number is busy when it links nowhere and is not the list tail.
  assign is_busy = (mem_q == '0) && (tail_r != n_r);

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    unique case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = ((clr_r == LAST) || (clr_r == '0)) ? '0 : clr_r + PTR_W'(1);
      end
      S_EXEC: begin
        res_valid = res_ready;
        unique case (act_r)
          ACT_ALLOC: begin
            if (head_r == '0) begin
              res.status = ST_EMPTY;
            end else begin
              res.granted_record = REC_W'(head_r);
              head_nxt           = mem_q;
              wr_en              = res_ready;
              wr_addr            = head_r;
              if (mem_q == '0) begin
                tail_nxt = '0;
              end
            end
          end
          ACT_FREE: begin
            if (!range_ok_r) begin
              res.status = ST_RANGE;
            end else if (!is_busy) begin
              res.status = ST_FREE;
            end else if (head_r == '0) begin
              head_nxt = n_r;
              tail_nxt = n_r;
            end else begin
              // The freed entry already holds zero, so only the old tail is linked.
              wr_en    = res_ready;
              wr_addr  = tail_r;
              wr_data  = n_r;
              tail_nxt = n_r;
            end
          end
          ACT_QUERY: begin
            if (!range_ok_r) begin
              res.status = ST_RANGE;
            end else begin
              res.busy_res = is_busy;
            end
          end
          default: begin
            res = '0;
          end
        endcase
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      head_r  <= PTR_W'(1);
      tail_r  <= LAST;
    end else begin
      unique case (state_r)
        S_INIT: begin
          if (clr_r == LAST) begin
            state_r <= S_IDLE;
          end else begin
            clr_r <= clr_r + PTR_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act_r      <= in_action;
            n_r        <= n_in;
            range_ok_r <= n_ok;
            state_r    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (res_ready) begin
            head_r  <= head_nxt;
            tail_r  <= tail_nxt;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_INIT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/fifo_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// fifo_free_list_allocator_top
// Record-number allocator with a FIFO free list in a next-pointer memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_ch    sink       action, record_number
//  out_ch   source     granted_record, busy_res, status
//
//  Each transaction has two steps: a memory read at acceptance, then the
//  update and write-back of the next-pointer memory in the execute state.
//  After reset a clearing pass over every entry rebuilds the list;
//  in_ch.ready stays low during it. A stalled result waits in the output
//  register while the next request is accepted and its memory read issued.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_free_list_allocator_top #(
  parameter int unsigned NUM_RECORDS = ffla_pkg::NUM_RECORDS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ffla_in_if.sink    in_ch,
  ffla_out_if.source out_ch
);

  import ffla_pkg::*;

  ffla_result_t res;
  ffla_result_t out_r;
  logic         res_valid;
  logic         res_ready;
  logic         out_valid_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  ffla_engine #(
    .NUM_RECORDS (NUM_RECORDS)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_action        (in_ch.action),
    .in_record_number (in_ch.record_number),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.granted_record = out_r.granted_record;
  assign out_ch.busy_res       = out_r.busy_res;
  assign out_ch.status         = out_r.status;

  a_grant_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.granted_record != '0) |-> (out_ch.status == ST_OK))
    else $error("granted record with a failure status");

  a_busy_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.busy_res |-> (out_ch.status == ST_OK) &&
    (out_ch.granted_record == '0))
    else $error("busy flag together with a grant or a failure status");

  a_clear_pass : assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ch.ready)
    else $error("request accepted before the clearing pass");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second request accepted while one is in progress");

endmodule

`default_nettype wire
